[sv/md4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 digest package
// Shared types and constants of the MD4 digest block: the word transaction
// that runs from the front end to the round engine, input kind codes and
// the fixed MD4 constants.
// ----------------------------------------------------------------------------
package md4_pkg;

    // Input item kinds carried on tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Initial chaining values.
    localparam logic [31:0] MD4_IV_A = 32'h67452301;
    localparam logic [31:0] MD4_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD4_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD4_IV_D = 32'h10325476;

    // Additive constants of rounds two and three.
    localparam logic [31:0] MD4_K2 = 32'h5A827999;
    localparam logic [31:0] MD4_K3 = 32'h6ED9EBA1;

    // One little-endian message word; fin marks the padding words of a message's last block.
    typedef struct packed {
        logic        fin;
        logic [31:0] word;
    } t_qword;

endpackage

[sv/md4_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 front end
// Accepts byte transactions, packs them little-endian into 32-bit words,
// keeps the message length and generates the padding and length words
// when an end item arrives.
// ----------------------------------------------------------------------------
module md4_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,   // data_byte[7:0]
    input  logic            i_s_tuser,   // kind[0]
    output md4_pkg::t_qword o_q_data,
    output logic            o_q_valid,
    input  logic            i_q_ready
);
    import md4_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PAD  = 2'b10
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [60:0] r_bytes, n_bytes;
    logic [23:0] r_acc, n_acc;
    logic [3:0]  r_wi, n_wi;
    logic        r_first, n_first;
    logic        r_extra, n_extra;

    logic        s_acc;
    logic [63:0] len_bits;
    logic [31:0] pad_word;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign len_bits = {r_bytes, 3'b000};

    // Bytes are taken only while not padding and while the queue has room.
    assign o_s_tready = (r_state == F_IDLE) && i_q_ready;

    // Padding word: the 0x80 marker after any held bytes, zeros, then the length.
    always_comb begin
        pad_word = 32'h0;
        if (r_first) begin
            case (r_bytes[1:0])
                2'd0:    pad_word = 32'h0000_0080;
                2'd1:    pad_word = {16'h0, 8'h80, r_acc[7:0]};
                2'd2:    pad_word = {8'h0, 8'h80, r_acc[15:0]};
                default: pad_word = {8'h80, r_acc[23:0]};
            endcase
        end else if (!r_extra && (r_wi == 4'd14)) begin
            pad_word = len_bits[31:0];
        end else if (!r_extra && (r_wi == 4'd15)) begin
            pad_word = len_bits[63:32];
        end
    end

    // Word output towards the queue.
    always_comb begin
        o_q_valid     = 1'b0;
        o_q_data.fin  = 1'b0;
        o_q_data.word = {i_s_tdata, r_acc};
        if (r_state == F_PAD) begin
            o_q_valid     = 1'b1;
            o_q_data.fin  = !r_extra;
            o_q_data.word = pad_word;
        end else begin
            o_q_valid = s_acc && (i_s_tuser == KIND_DATA) && (r_bytes[1:0] == 2'd3);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_bytes = r_bytes;
        n_acc   = r_acc;
        n_wi    = r_wi;
        n_first = r_first;
        n_extra = r_extra;
        case (r_state)
            F_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == KIND_DATA) begin
                        n_bytes = r_bytes + 61'd1;
                        case (r_bytes[1:0])
                            2'd0:    n_acc[7:0]   = i_s_tdata;
                            2'd1:    n_acc[15:8]  = i_s_tdata;
                            2'd2:    n_acc[23:16] = i_s_tdata;
                            default: n_acc        = r_acc;
                        endcase
                    end else begin
                        n_state = F_PAD;
                        n_wi    = r_bytes[5:2];
                        n_first = 1'b1;
                        n_extra = (r_bytes[5:0] >= 6'd56);
                    end
                end
            end
            F_PAD: begin
                if (i_q_ready) begin
                    n_first = 1'b0;
                    n_wi    = r_wi + 4'd1;
                    if (r_wi == 4'd15) begin
                        if (r_extra) begin
                            n_extra = 1'b0;
                        end else begin
                            n_state = F_IDLE;
                            n_bytes = 61'd0;
                        end
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_bytes <= 61'd0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
            r_wi    <= 4'd0;
        end else begin
            r_state <= n_state;
            r_bytes <= n_bytes;
            r_first <= n_first;
            r_extra <= n_extra;
            r_wi    <= n_wi;
        end
        r_acc <= n_acc;
    end

endmodule

[sv/md4_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 word queue
// Short first-in first-out queue of word transactions between the front
// end and the round engine, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module md4_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  md4_pkg::t_qword i_wr_data,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    output md4_pkg::t_qword o_rd_data,
    output logic            o_rd_valid,
    input  logic            i_rd_ready
);
    import md4_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qword          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            push, pop;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    // Registers and storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

endmodule

[sv/md4_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 round engine
// Collects word transactions into a double-buffered block store and runs
// the 48 MD4 steps, one step per cycle, on each full block. After the last
// block of a message it presents the digest and restores the chaining values.
// ----------------------------------------------------------------------------
module md4_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  md4_pkg::t_qword i_q_data,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [127:0]    o_m_tdata   // digest_low[63:0], digest_high[127:64]
);
    import md4_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_ADD  = 3'b100
    } t_bstate;

    // Message word index used by a given step.
    function automatic logic [3:0] word_index(input logic [5:0] step);
        logic [3:0] m;
        m = step[3:0];
        case (step[5:4])
            2'd0:    word_index = m;
            2'd1:    word_index = {m[1:0], m[3:2]};
            default: word_index = {m[0], m[1], m[2], m[3]};
        endcase
    endfunction

    // Rotation amount of a given step.
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        case ({step[5:4], step[1:0]})
            4'b00_00: rot_amount = 5'd3;
            4'b00_01: rot_amount = 5'd7;
            4'b00_10: rot_amount = 5'd11;
            4'b00_11: rot_amount = 5'd19;
            4'b01_00: rot_amount = 5'd3;
            4'b01_01: rot_amount = 5'd5;
            4'b01_10: rot_amount = 5'd9;
            4'b01_11: rot_amount = 5'd13;
            4'b10_00: rot_amount = 5'd3;
            4'b10_01: rot_amount = 5'd9;
            4'b10_10: rot_amount = 5'd11;
            default:  rot_amount = 5'd15;
        endcase
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        rotl32 = t[63:32];
    endfunction

    t_bstate     r_state, n_state;
    logic [31:0] r_wmem [32];
    logic [31:0] r_rdata;
    logic [1:0]  r_full, n_full;
    logic [1:0]  r_fin, n_fin;
    logic        r_wbank, n_wbank;
    logic        r_cbank, n_cbank;
    logic [3:0]  r_wcnt, n_wcnt;
    logic [5:0]  r_step, n_step;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_ch_a, r_ch_b, r_ch_c, r_ch_d;
    logic [31:0] n_ch_a, n_ch_b, n_ch_c, n_ch_d;
    logic        r_ovalid, n_ovalid;
    logic [127:0] r_odata, n_odata;

    logic        wr_en;
    logic [3:0]  rd_idx;
    logic [5:0]  step_next;
    logic [31:0] fval, kval, sum, anew;
    logic [31:0] sum_a, sum_b, sum_c, sum_d;
    logic        out_free;

    assign o_q_ready  = !r_full[r_wbank];
    assign wr_en      = i_q_valid && o_q_ready;
    assign step_next  = r_step + 6'd1;
    assign rd_idx     = (r_state == B_RUN) ? word_index(step_next) : 4'd0;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign out_free   = !r_ovalid || i_m_tready;

    // One MD4 step on the working registers.
    always_comb begin
        case (r_step[5:4])
            2'd0: begin
                fval = (r_b & r_c) | (~r_b & r_d);
                kval = 32'h0;
            end
            2'd1: begin
                fval = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                kval = MD4_K2;
            end
            default: begin
                fval = r_b ^ r_c ^ r_d;
                kval = MD4_K3;
            end
        endcase
        sum  = r_a + fval + r_rdata + kval;
        anew = rotl32(sum, rot_amount(r_step));
    end

    // Chaining values plus the working registers at the end of a block.
    assign sum_a = r_ch_a + r_a;
    assign sum_b = r_ch_b + r_b;
    assign sum_c = r_ch_c + r_c;
    assign sum_d = r_ch_d + r_d;

    // Block store fill side and engine control.
    always_comb begin
        n_state  = r_state;
        n_full   = r_full;
        n_fin    = r_fin;
        n_wbank  = r_wbank;
        n_cbank  = r_cbank;
        n_wcnt   = r_wcnt;
        n_step   = r_step;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_ch_a   = r_ch_a;
        n_ch_b   = r_ch_b;
        n_ch_c   = r_ch_c;
        n_ch_d   = r_ch_d;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;

        // Fill side: sixteen words make a bank full.
        if (wr_en) begin
            n_wcnt = r_wcnt + 4'd1;
            if (r_wcnt == 4'd15) begin
                n_full[r_wbank] = 1'b1;
                n_fin[r_wbank]  = i_q_data.fin;
                n_wbank         = !r_wbank;
            end
        end

        case (r_state)
            B_IDLE: begin
                if (r_full[r_cbank]) begin
                    n_state = B_RUN;
                    n_step  = 6'd0;
                    n_a     = r_ch_a;
                    n_b     = r_ch_b;
                    n_c     = r_ch_c;
                    n_d     = r_ch_d;
                end
            end
            B_RUN: begin
                n_a    = r_d;
                n_b    = anew;
                n_c    = r_b;
                n_d    = r_c;
                n_step = step_next;
                if (r_step == 6'd47) begin
                    n_state = B_ADD;
                end
            end
            B_ADD: begin
                if (!r_fin[r_cbank]) begin
                    n_ch_a          = sum_a;
                    n_ch_b          = sum_b;
                    n_ch_c          = sum_c;
                    n_ch_d          = sum_d;
                    n_full[r_cbank] = 1'b0;
                    n_cbank         = !r_cbank;
                    n_state         = B_IDLE;
                end else if (out_free) begin
                    n_odata         = {sum_d, sum_c, sum_b, sum_a};
                    n_ovalid        = 1'b1;
                    n_ch_a          = MD4_IV_A;
                    n_ch_b          = MD4_IV_B;
                    n_ch_c          = MD4_IV_C;
                    n_ch_d          = MD4_IV_D;
                    n_full[r_cbank] = 1'b0;
                    n_cbank         = !r_cbank;
                    n_state         = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Block store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wmem[{r_wbank, r_wcnt}] <= i_q_data.word;
        end
        r_rdata <= r_wmem[{r_cbank, rd_idx}];
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_full   <= 2'b00;
            r_fin    <= 2'b00;
            r_wbank  <= 1'b0;
            r_cbank  <= 1'b0;
            r_wcnt   <= 4'd0;
            r_step   <= 6'd0;
            r_ch_a   <= MD4_IV_A;
            r_ch_b   <= MD4_IV_B;
            r_ch_c   <= MD4_IV_C;
            r_ch_d   <= MD4_IV_D;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_full   <= n_full;
            r_fin    <= n_fin;
            r_wbank  <= n_wbank;
            r_cbank  <= n_cbank;
            r_wcnt   <= n_wcnt;
            r_step   <= n_step;
            r_ch_a   <= n_ch_a;
            r_ch_b   <= n_ch_b;
            r_ch_c   <= n_ch_c;
            r_ch_d   <= n_ch_d;
            r_ovalid <= n_ovalid;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_odata <= n_odata;
    end

endmodule

[sv/md4_message_digest_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 message digest, top level
// Streams message bytes in and returns one 128-bit MD4 digest for each end
// of message transaction.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle on the slave stream while its
// word queue has room; a front end packs bytes into words, and a round engine
// runs the 48 MD4 steps at one step per cycle on a double-buffered block
// store, so sustained input holds at one byte per cycle. An end of message
// transaction (tuser high) makes the front end write padding and length
// words, during which no byte is accepted; the digest appears on the master
// stream once the final block has gone through the round engine, and waits
// in an output register until it is taken.
module md4_message_digest_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // data_byte[7:0]
    input  logic         i_s_tuser,   // kind[0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata    // digest_low[63:0], digest_high[127:64]
);
    import md4_pkg::*;

    t_qword front_data, queue_data;
    logic   front_valid, front_ready;
    logic   queue_valid, queue_ready;

    // Front end: byte packing and padding.
    md4_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_data   (front_data),
        .o_q_valid  (front_valid),
        .i_q_ready  (front_ready)
    );

    // Word queue between the two halves.
    md4_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_data  (front_data),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .o_rd_data  (queue_data),
        .o_rd_valid (queue_valid),
        .i_rd_ready (queue_ready)
    );

    // Round engine and digest output.
    md4_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (queue_data),
        .i_q_valid  (queue_valid),
        .o_q_ready  (queue_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
